[hdl/assert_macros.svh]
// assertion helpers, included by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hdl/rqra_pkg.sv]
package rqra_pkg;

  // field widths
  localparam int CMD_W   = 2;
  localparam int MONTH_W = 4;
  localparam int RAIN_W  = 10;
  localparam int TEMP_W  = 7;
  localparam int STAT_W  = 2;
  localparam int AVG_W   = 14;
  localparam int OCC_W   = 4;
  localparam int FRAC_W  = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AVERAGE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // one stored record
  typedef struct packed {
    logic [MONTH_W-1:0]       month;
    logic [RAIN_W-1:0]        rain;
    logic signed [TEMP_W-1:0] temp;
  } rec_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/rqra_div.sv]
module rqra_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;
  logic              fits;

  // one restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    trial   = shifted - {1'b0, dvs};
    fits    = !trial[DVS_W];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= STEP_W'(DVD_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[hdl/rqra_datapath.sv]
`include "assert_macros.svh"

module rqra_datapath #(
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rqra_pkg::ctrl_cmd_t                  cmd,
  output rqra_pkg::dp_stat_t                   stat,
  input  logic [rqra_pkg::CMD_W-1:0]           command,
  input  logic [rqra_pkg::MONTH_W-1:0]         month_number,
  input  logic [rqra_pkg::RAIN_W-1:0]          rainfall_cm,
  input  logic signed [rqra_pkg::TEMP_W-1:0]   temperature_c,
  output logic [rqra_pkg::STAT_W-1:0]          status,
  output logic [rqra_pkg::MONTH_W-1:0]         out_month,
  output logic [rqra_pkg::RAIN_W-1:0]          out_rainfall,
  output logic signed [rqra_pkg::TEMP_W-1:0]   out_temperature,
  output logic [rqra_pkg::AVG_W-1:0]           average_rain,
  output logic [rqra_pkg::OCC_W-1:0]           occupancy,
  output logic                                 out_valid,
  input  logic                                 out_ready
);

  import rqra_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = $clog2(DEPTH * ((1 << RAIN_W) - 1) + 1);
  localparam int DVD_W = SUM_W + FRAC_W;

  // record memory
  rec_t mem [DEPTH];
  rec_t rd_rec;

  // latched item
  logic [CMD_W-1:0]        cmd_q;
  rec_t                    in_rec;

  // queue state
  logic [PTR_W-1:0] head_ptr, head_ptr_next;
  logic [PTR_W-1:0] tail_ptr, tail_ptr_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [SUM_W-1:0] rain_sum, rain_sum_next;
  logic             wr_en;

  // result of the current item
  logic [STAT_W-1:0]        res_status;
  rec_t                     res_rec;
  logic [AVG_W-1:0]         res_avg;

  // divider
  logic [DVD_W-1:0] quotient;
  logic             div_done;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  // item register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q       <= command;
      in_rec.month <= month_number;
      in_rec.rain  <= rainfall_cm;
      in_rec.temp  <= temperature_c;
    end
  end

  // memory write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_ptr] <= in_rec;
    end
    rd_rec <= mem[head_ptr];
  end

  rqra_div #(
    .DVD_W(DVD_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({rain_sum, FRAC_W'(0)}),
    .divisor  (fill_count),
    .quotient (quotient),
    .done     (div_done)
  );

  // result and next queue state
  always_comb begin
    res_status      = STAT_OK;
    res_rec         = '0;
    res_avg         = '0;
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    fill_count_next = fill_count;
    rain_sum_next   = rain_sum;
    wr_en           = 1'b0;
    case (cmd_q)
      CMD_INSERT: begin
        if (fill_count == CNT_W'(DEPTH)) begin
          res_status = STAT_FULL;
        end else begin
          wr_en           = cmd.commit;
          tail_ptr_next   = advance(tail_ptr);
          fill_count_next = fill_count + 1'b1;
          rain_sum_next   = rain_sum + SUM_W'(in_rec.rain);
        end
      end
      CMD_DELETE: begin
        if (fill_count == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          res_rec         = rd_rec;
          head_ptr_next   = advance(head_ptr);
          fill_count_next = fill_count - 1'b1;
          rain_sum_next   = (rain_sum >= SUM_W'(rd_rec.rain)) ?
                            rain_sum - SUM_W'(rd_rec.rain) : '0;
        end
      end
      CMD_AVERAGE: begin
        if (fill_count == '0) begin
          res_status = STAT_EMPTY;
        end else begin
          res_avg = quotient[AVG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= '0;
      tail_ptr   <= '0;
      fill_count <= '0;
      rain_sum   <= '0;
    end else if (cmd.commit) begin
      head_ptr   <= head_ptr_next;
      tail_ptr   <= tail_ptr_next;
      fill_count <= fill_count_next;
      rain_sum   <= rain_sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= res_status;
      out_month       <= res_rec.month;
      out_rainfall    <= res_rec.rain;
      out_temperature <= res_rec.temp;
      average_rain    <= res_avg;
      occupancy       <= OCC_W'(fill_count_next);
    end
  end

  // status to the controller
  always_comb begin
    stat.need_div = (cmd_q == CMD_AVERAGE) && (fill_count != '0);
    stat.div_done = div_done;
    stat.out_free = !out_valid || out_ready;
  end

  `ASSERT_CLK(a_count_bound, fill_count <= CNT_W'(DEPTH), "fill count above depth")
  `ASSERT_CLK(a_commit_free, cmd.commit |-> stat.out_free, "result written over a waiting item")
  `ASSERT_CLK(a_empty_sum, fill_count == '0 |-> rain_sum == '0, "rain sum left on empty queue")

endmodule

[hdl/rqra_ctrl.sv]
module rqra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rqra_pkg::dp_stat_t  stat,
  output rqra_pkg::ctrl_cmd_t cmd
);

  import rqra_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = stat.need_div ? S_DIVIDE : S_COMMIT;
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.div_start = stat.need_div;
      end
      S_DIVIDE: begin
      end
      S_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/ring_queue_running_average_core.sv]
// Circular queue of weather records (month, rainfall, temperature) with a
// running rainfall sum. Items come in on the in_valid/in_ready channel, one
// command each: insert a record, delete the oldest one, or query the average
// rainfall. Every item gives exactly one result on out_valid/out_ready: a
// status, the deleted record, the average (sum*16/count, truncated) and the
// number of records held afterwards.
// Insert and delete pass from acceptance through the decode and commit states
// into the output register; the next item is taken once the commit is done.
// An average query on a non-empty queue runs the radix-2 divider, one
// quotient bit per cycle over SUM_W+4 bits (17 for DEPTH 8), between the
// decode and commit states.
// The queue takes items one at a time; a new item is accepted while the
// previous result still waits in the output register. If the receiver
// stalls, the next result is held inside until the output register frees.
// Reset empties the queue (pointers, count and sum to zero); the record
// memory itself is not cleared.
module ring_queue_running_average_core #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rqra_pkg::CMD_W-1:0]         command,
  input  logic [rqra_pkg::MONTH_W-1:0]       month_number,
  input  logic [rqra_pkg::RAIN_W-1:0]        rainfall_cm,
  input  logic signed [rqra_pkg::TEMP_W-1:0] temperature_c,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rqra_pkg::STAT_W-1:0]        status,
  output logic [rqra_pkg::MONTH_W-1:0]       out_month,
  output logic [rqra_pkg::RAIN_W-1:0]        out_rainfall,
  output logic signed [rqra_pkg::TEMP_W-1:0] out_temperature,
  output logic [rqra_pkg::AVG_W-1:0]         average_rain,
  output logic [rqra_pkg::OCC_W-1:0]         occupancy
);

  import rqra_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing
  rqra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue storage, arithmetic and output register
  rqra_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (command),
    .month_number    (month_number),
    .rainfall_cm     (rainfall_cm),
    .temperature_c   (temperature_c),
    .status          (status),
    .out_month       (out_month),
    .out_rainfall    (out_rainfall),
    .out_temperature (out_temperature),
    .average_rain    (average_rain),
    .occupancy       (occupancy),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule

[bench/ring_queue_running_average_check.sv]
// watches both channels, keeps a shadow of the record ring and checks every result
module ring_queue_running_average_check #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [rqra_pkg::CMD_W-1:0]         command,
  input  logic [rqra_pkg::MONTH_W-1:0]       month_number,
  input  logic [rqra_pkg::RAIN_W-1:0]        rainfall_cm,
  input  logic signed [rqra_pkg::TEMP_W-1:0] temperature_c,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [rqra_pkg::STAT_W-1:0]        status,
  input  logic [rqra_pkg::MONTH_W-1:0]       out_month,
  input  logic [rqra_pkg::RAIN_W-1:0]        out_rainfall,
  input  logic signed [rqra_pkg::TEMP_W-1:0] out_temperature,
  input  logic [rqra_pkg::AVG_W-1:0]         average_rain,
  input  logic [rqra_pkg::OCC_W-1:0]         occupancy,
  output int                                 error_count,
  output int                                 pending_count,
  output int                                 result_count
);

  import rqra_pkg::*;

  // one result as the queue should report it
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [MONTH_W-1:0]       month;
    logic [RAIN_W-1:0]        rain;
    logic signed [TEMP_W-1:0] temp;
    logic [AVG_W-1:0]         avg;
    logic [OCC_W-1:0]         occ;
  } weather_reply_t;

  weather_reply_t reply_queue[$];

  // shadow of the record ring
  rec_t shadow_ring [DEPTH];
  int   oldest_slot;
  int   free_slot;
  int   record_count;
  int   rain_total;

  // apply one command to the shadow ring and return the reply it should give
  function automatic weather_reply_t apply_command(
    input logic [CMD_W-1:0]         cmd,
    input logic [MONTH_W-1:0]       month,
    input logic [RAIN_W-1:0]        rain,
    input logic signed [TEMP_W-1:0] temp
  );
    weather_reply_t r;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (record_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_ring[free_slot].month = month;
          shadow_ring[free_slot].rain  = rain;
          shadow_ring[free_slot].temp  = temp;
          free_slot    = (free_slot + 1) % DEPTH;
          record_count = record_count + 1;
          rain_total   = rain_total + int'(rain);
        end
      end
      CMD_DELETE: begin
        if (record_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.month      = shadow_ring[oldest_slot].month;
          r.rain       = shadow_ring[oldest_slot].rain;
          r.temp       = shadow_ring[oldest_slot].temp;
          oldest_slot  = (oldest_slot + 1) % DEPTH;
          record_count = record_count - 1;
          rain_total   = rain_total - int'(r.rain);
        end
      end
      CMD_AVERAGE: begin
        if (record_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.avg = AVG_W'((rain_total << FRAC_W) / record_count);
        end
      end
      default: begin
        // spare code does nothing
      end
    endcase
    r.occ = OCC_W'(record_count);
    return r;
  endfunction

  // report one field that differs
  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      error_count = error_count + 1;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // compare on accepted results first, then log the accepted item
  always @(posedge clk) begin
    weather_reply_t want;
    if (rst) begin
      reply_queue.delete();
      oldest_slot  = 0;
      free_slot    = 0;
      record_count = 0;
      rain_total   = 0;
      error_count  = 0;
      result_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count = result_count + 1;
        if (reply_queue.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t: result with none expected, status %0d occupancy %0d",
                   $time, status, occupancy);
        end else begin
          want = reply_queue.pop_front();
          check_field("status", int'(want.status), int'(status));
          check_field("out_month", int'(want.month), int'(out_month));
          check_field("out_rainfall", int'(want.rain), int'(out_rainfall));
          check_field("out_temperature", int'(want.temp), int'(out_temperature));
          check_field("average_rain", int'(want.avg), int'(average_rain));
          check_field("occupancy", int'(want.occ), int'(occupancy));
        end
      end
      if (in_valid && in_ready) begin
        reply_queue.push_back(apply_command(command, month_number, rainfall_cm,
                                            temperature_c));
      end
    end
    pending_count = reply_queue.size();
  end

endmodule

[bench/ring_queue_running_average_core_test.sv]
// drives weather records and commands into the queue and gives the verdict
module ring_queue_running_average_core_test;
  import rqra_pkg::*;

  localparam int QUEUE_DEPTH = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_WAIT = 13;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [CMD_W-1:0]         command;
  logic [MONTH_W-1:0]       month_number;
  logic [RAIN_W-1:0]        rainfall_cm;
  logic signed [TEMP_W-1:0] temperature_c;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        status;
  logic [MONTH_W-1:0]       out_month;
  logic [RAIN_W-1:0]        out_rainfall;
  logic signed [TEMP_W-1:0] out_temperature;
  logic [AVG_W-1:0]         average_rain;
  logic [OCC_W-1:0]         occupancy;

  int error_count;
  int pending_count;
  int result_count;
  int cycle_count = 0;
  int insert_count = 0;
  int delete_count = 0;
  int query_count = 0;
  int spare_count = 0;
  bit tx_gappy = 1'b1;
  bit rx_gappy = 1'b1;

  ring_queue_running_average_core #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .month_number(month_number),
    .rainfall_cm(rainfall_cm),
    .temperature_c(temperature_c),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_month(out_month),
    .out_rainfall(out_rainfall),
    .out_temperature(out_temperature),
    .average_rain(average_rain),
    .occupancy(occupancy)
  );

  ring_queue_running_average_check #(
    .DEPTH(QUEUE_DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .month_number(month_number),
    .rainfall_cm(rainfall_cm),
    .temperature_c(temperature_c),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_month(out_month),
    .out_rainfall(out_rainfall),
    .out_temperature(out_temperature),
    .average_rain(average_rain),
    .occupancy(occupancy),
    .error_count(error_count),
    .pending_count(pending_count),
    .result_count(result_count)
  );

  // clock
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one item, starting and ending at a falling edge
  task automatic push_item(
    input logic [CMD_W-1:0]         cmd,
    input logic [MONTH_W-1:0]       month,
    input logic [RAIN_W-1:0]        rain,
    input logic signed [TEMP_W-1:0] temp
  );
    int gap;
    gap = tx_gappy ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    month_number  <= month;
    rainfall_cm   <= rain;
    temperature_c <= temp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (cmd)
      CMD_INSERT:  insert_count++;
      CMD_DELETE:  delete_count++;
      CMD_AVERAGE: query_count++;
      default:     spare_count++;
    endcase
    @(negedge clk);
  endtask

  // hold the sender until the queue has answered everything
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  // receiver with random stalls per result
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_gappy ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    logic [CMD_W-1:0]         cmd;
    logic [MONTH_W-1:0]       month;
    logic [RAIN_W-1:0]        rain;
    logic signed [TEMP_W-1:0] temp;
    int                       bias;
    rst           = 1'b1;
    in_valid      = 1'b0;
    command       = CMD_INSERT;
    month_number  = '0;
    rainfall_cm   = '0;
    temperature_c = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue: query and delete both flag empty
    push_item(CMD_AVERAGE, 4'd5, 10'd300, 7'sd10);
    push_item(CMD_DELETE, 4'd5, 10'd300, 7'sd10);
    // fill to the brim with extreme records, including odd month codes
    push_item(CMD_INSERT, 4'd0, 10'd0, -7'sd64);
    push_item(CMD_INSERT, 4'd15, 10'd1023, 7'sd63);
    push_item(CMD_INSERT, 4'd1, 10'd1023, -7'sd1);
    push_item(CMD_INSERT, 4'd12, 10'd1023, 7'sd0);
    push_item(CMD_INSERT, 4'd13, 10'd682, 7'sd21);
    push_item(CMD_INSERT, 4'd6, 10'd341, -7'sd42);
    push_item(CMD_INSERT, 4'd14, 10'd1023, 7'sd63);
    push_item(CMD_INSERT, 4'd7, 10'd1, -7'sd64);
    // full queue rejects inserts
    push_item(CMD_INSERT, 4'd9, 10'd512, 7'sd5);
    push_item(CMD_INSERT, 4'd15, 10'd1023, 7'sd63);
    push_item(CMD_AVERAGE, 4'd0, 10'd0, 7'sd0);
    push_item(CMD_SPARE, 4'd15, 10'd1023, -7'sd1);
    // drain completely, then once more past empty
    repeat (QUEUE_DEPTH + 1) push_item(CMD_DELETE, 4'd0, 10'd0, 7'sd0);
    push_item(CMD_AVERAGE, 4'd15, 10'd1023, 7'sd63);
    drain_results();

    // random walk with changing fill bias and idling style
    for (int chunk = 0; chunk < 48; chunk++) begin
      bias = 20 + 30 * $urandom_range(0, 2);
      tx_gappy = ($urandom_range(0, 3) != 0);
      rx_gappy = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) drain_results();
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 99) < 3) cmd = CMD_SPARE;
        else if ($urandom_range(0, 99) < bias) cmd = CMD_INSERT;
        else if ($urandom_range(0, 2) == 0) cmd = CMD_AVERAGE;
        else cmd = CMD_DELETE;
        month = MONTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
                                                       $urandom_range(1, 12));
        case ($urandom_range(0, 7))
          0:       rain = '0;
          1:       rain = '1;
          default: rain = RAIN_W'($urandom_range(0, 1023));
        endcase
        temp = TEMP_W'($urandom_range(0, 127));
        push_item(cmd, month, rain, temp);
      end
    end
    in_valid <= 1'b0;

    // let the last results through, then allow time for strays
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d inserts, %0d deletes, %0d average queries, %0d spare codes",
             insert_count, delete_count, query_count, spare_count);
    $display("%0d results checked in %0d cycles", result_count, cycle_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
